// ===== hw/rtl/lps_pkg.sv =====
`default_nettype none

package lps_pkg;

	// register indexes on the configuration channel
	localparam int unsigned CFG_INDEX_BITS = 4;
	localparam int unsigned CFG_DATA_BITS  = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_PITCH  = 4'd0,
		REG_PIXEL_BITS = 4'd1
	} reg_index_t;

	// fixed field widths
	localparam int unsigned PITCH_BITS  = 16;
	localparam int unsigned PXBITS_BITS = 6;
	localparam int unsigned BPP_BITS    = 3;
	localparam int unsigned OFFSET_BITS = 28;
	localparam int unsigned INK_BITS    = 32;
	localparam int unsigned BYTE_SHIFT  = 3;

	localparam logic [PITCH_BITS-1:0]  PITCH_RESET  = 16'd16384;
	localparam logic [PXBITS_BITS-1:0] PXBITS_RESET = 6'd32;

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// travel direction on one axis
	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_PLUS  = 2'd1,
		DIR_MINUS = 2'd2
	} dir_t;

	// frame buffer layout settings
	typedef struct packed {
		logic [PITCH_BITS-1:0]  row_pitch_bytes;
		logic [PXBITS_BITS-1:0] pixel_bits;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lps_cfg_regs.sv =====
`default_nettype none

module lps_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [lps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output lps_pkg::cfg_t                            cfg
);

	lps_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg          = cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_pitch_bytes <= lps_pkg::PITCH_RESET;
			cfg_q.pixel_bits      <= lps_pkg::PXBITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lps_pkg::REG_ROW_PITCH: begin
					cfg_q.row_pitch_bytes <= cfg_data;
				end
				lps_pkg::REG_PIXEL_BITS: begin
					cfg_q.pixel_bits <= cfg_data[lps_pkg::PXBITS_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lps_offset.sv =====
`default_nettype none

module lps_offset #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic [COORD_BITS-1:0]            pixel_x,
	input  wire logic [COORD_BITS-1:0]            pixel_y,
	input  wire lps_pkg::cfg_t                    cfg,
	output logic [lps_pkg::OFFSET_BITS-1:0]       byte_offset
);

	localparam int unsigned ROW_W = COORD_BITS + lps_pkg::PITCH_BITS;
	localparam int unsigned SUM_W = ROW_W + 1;

	logic [lps_pkg::BPP_BITS-1:0] bpp;
	logic [ROW_W-1:0]             row_part;
	logic [ROW_W-1:0]             col_part;
	logic [SUM_W-1:0]             sum;

	// bytes per pixel rounded down
	assign bpp = lps_pkg::BPP_BITS'(cfg.pixel_bits >> lps_pkg::BYTE_SHIFT);

	// row times pitch plus column times bytes per pixel, wrapped to offset width
	assign row_part    = ROW_W'(pixel_y) * ROW_W'(cfg.row_pitch_bytes);
	assign col_part    = ROW_W'(pixel_x) * ROW_W'(bpp);
	assign sum         = SUM_W'(row_part) + SUM_W'(col_part);
	assign byte_offset = lps_pkg::OFFSET_BITS'(sum);

endmodule

`default_nettype wire

// ===== hw/rtl/lps_stepper.sv =====
`default_nettype none

module lps_stepper #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            command,
	input  wire logic [COORD_BITS-1:0]           start_x,
	input  wire logic [COORD_BITS-1:0]           start_y,
	input  wire logic [COORD_BITS-1:0]           end_x,
	input  wire logic [COORD_BITS-1:0]           end_y,
	input  wire logic [lps_pkg::INK_BITS-1:0]    ink,
	output logic                                 emit,
	output logic [COORD_BITS-1:0]                pixel_x,
	output logic [COORD_BITS-1:0]                pixel_y,
	output logic [lps_pkg::INK_BITS-1:0]         pixel_value,
	output logic                                 last
);

	localparam int unsigned PROD_W = 2 * COORD_BITS;
	localparam logic [COORD_BITS-1:0] SPAN_FLOOR = COORD_BITS'(1);

	logic [COORD_BITS-1:0]       cur_col_q, cur_row_q, goal_col_q, goal_row_q;
	logic [COORD_BITS-1:0]       span_col_q, span_row_q;
	lps_pkg::dir_t               dir_col_q, dir_row_q;
	logic [lps_pkg::INK_BITS-1:0] held_ink_q;
	logic                        active_q;

	logic [COORD_BITS-1:0] rem_col, rem_row;
	logic [PROD_W-1:0]     lhs, rhs;
	logic [COORD_BITS-1:0] next_col, next_row;
	logic [COORD_BITS-1:0] load_span_col, load_span_row;

	function automatic logic [COORD_BITS-1:0] gap(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic lps_pkg::dir_t dir_of(
		input logic [COORD_BITS-1:0] from,
		input logic [COORD_BITS-1:0] to
	);
		if (to > from) begin
			return lps_pkg::DIR_PLUS;
		end else if (to < from) begin
			return lps_pkg::DIR_MINUS;
		end
		return lps_pkg::DIR_NONE;
	endfunction

	function automatic logic [COORD_BITS-1:0] move(
		input logic [COORD_BITS-1:0] v,
		input lps_pkg::dir_t         dir
	);
		logic [COORD_BITS-1:0] r;
		case (dir)
			lps_pkg::DIR_PLUS:  r = v + SPAN_FLOOR;
			lps_pkg::DIR_MINUS: r = v - SPAN_FLOOR;
			default:            r = v;
		endcase
		return r;
	endfunction

	// remaining slope against original slope by cross products
	assign rem_col = gap(cur_col_q, goal_col_q);
	assign rem_row = gap(cur_row_q, goal_row_q);
	assign lhs     = PROD_W'(rem_col) * PROD_W'(span_row_q);
	assign rhs     = PROD_W'(span_col_q) * PROD_W'(rem_row);

	always_comb begin
		next_col = cur_col_q;
		next_row = cur_row_q;
		if (lhs < rhs) begin
			next_row = move(cur_row_q, dir_row_q);
		end else if (lhs > rhs) begin
			next_col = move(cur_col_q, dir_col_q);
		end else begin
			next_row = move(cur_row_q, dir_row_q);
			next_col = move(cur_col_q, dir_col_q);
		end
	end

	// emitted pixel is the current one
	assign emit        = (command == lps_pkg::CMD_STEP) && active_q;
	assign pixel_x     = cur_col_q;
	assign pixel_y     = cur_row_q;
	assign pixel_value = held_ink_q;
	assign last        = (next_col == goal_col_q) && (next_row == goal_row_q);

	// zero spans are held as one
	assign load_span_col = (gap(start_x, end_x) == '0) ? SPAN_FLOOR : gap(start_x, end_x);
	assign load_span_row = (gap(start_y, end_y) == '0) ? SPAN_FLOOR : gap(start_y, end_y);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			goal_col_q <= '0;
			goal_row_q <= '0;
			span_col_q <= '0;
			span_row_q <= SPAN_FLOOR;
			dir_col_q  <= lps_pkg::DIR_NONE;
			dir_row_q  <= lps_pkg::DIR_NONE;
			held_ink_q <= '0;
			active_q   <= 1'b0;
		end else if (en) begin
			if (command == lps_pkg::CMD_LOAD) begin
				cur_col_q  <= start_x;
				cur_row_q  <= start_y;
				goal_col_q <= end_x;
				goal_row_q <= end_y;
				span_col_q <= load_span_col;
				span_row_q <= load_span_row;
				dir_col_q  <= dir_of(start_x, end_x);
				dir_row_q  <= dir_of(start_y, end_y);
				held_ink_q <= ink;
				active_q   <= (start_x != end_x) || (start_y != end_y);
			end else if (active_q) begin
				cur_col_q <= next_col;
				cur_row_q <= next_row;
				active_q  <= !last;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/line_pixel_stepper_top.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// s_*       in         s_tvalid / s_tready        s_tdata line item, s_tuser command
// m_*       out        m_tvalid / m_tready        m_tdata pixel, m_tlast end of line
// cfg_*     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one item per cycle unless a stalled output holds a pixel; the stepping loop
// closes combinationally through the two cross products and their compare on the
// line state registers. a pixel passes the input and output registers. reset
// clears the line state and handshake valids and presets the layout registers.
// a stalled output holds its pixel while the input register takes loads,
// idle steps, or any step when the output register drains in the same cycle.

module line_pixel_stepper_top #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// start_x, start_y, end_x, end_y, ink, zero pad
	input  wire logic [((4*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
	// command
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// pixel_x, pixel_y, byte_offset, pixel_value, zero pad
	output logic [((2*COORD_BITS+60+7)/8)*8-1:0]     m_tdata,
	output logic                                     m_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [lps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int unsigned C      = COORD_BITS;
	localparam int unsigned OW     = lps_pkg::OFFSET_BITS;
	localparam int unsigned IW     = lps_pkg::INK_BITS;
	localparam int unsigned OUT_W  = 2 * C + OW + IW;
	localparam int unsigned M_W    = ((2 * C + OW + IW + 7) / 8) * 8;

	lps_pkg::cfg_t cfg;

	logic                   valid_s1;
	logic                   cmd_s1;
	logic [C-1:0]           sx_s1, sy_s1, ex_s1, ey_s1;
	logic [IW-1:0]          ink_s1;

	logic                   emit;
	logic                   advance;
	logic [C-1:0]           pix_x, pix_y;
	logic [IW-1:0]          pix_val;
	logic                   pix_last;
	logic [OW-1:0]          pix_off;

	logic                   valid_s2;
	logic [OUT_W-1:0]       data_s2;
	logic                   last_s2;

	lps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register moves on unless its pixel must wait for the output side
	assign advance  = valid_s1 && (!valid_s2 || m_tready || !emit);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			sx_s1  <= s_tdata[C-1:0];
			sy_s1  <= s_tdata[2*C-1:C];
			ex_s1  <= s_tdata[3*C-1:2*C];
			ey_s1  <= s_tdata[4*C-1:3*C];
			ink_s1 <= s_tdata[4*C+IW-1:4*C];
		end
	end

	lps_stepper #(
		.COORD_BITS (C)
	) u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.command     (cmd_s1),
		.start_x     (sx_s1),
		.start_y     (sy_s1),
		.end_x       (ex_s1),
		.end_y       (ey_s1),
		.ink         (ink_s1),
		.emit        (emit),
		.pixel_x     (pix_x),
		.pixel_y     (pix_y),
		.pixel_value (pix_val),
		.last        (pix_last)
	);

	lps_offset #(
		.COORD_BITS (C)
	) u_offset (
		.pixel_x     (pix_x),
		.pixel_y     (pix_y),
		.cfg         (cfg),
		.byte_offset (pix_off)
	);

	// output register holds one pixel until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			data_s2 <= {pix_val, pix_off, pix_y, pix_x};
			last_s2 <= pix_last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = M_W'(data_s2);
	assign m_tlast  = last_s2;

endmodule

`default_nettype wire
